@@ rtl/core/spf_pkg.sv @@
package spf_pkg;

    // Per-byte frame status
    typedef enum logic [1:0] {
        ST_BUSY     = 2'd0,
        ST_GOOD     = 2'd1,
        ST_CHK_ERR  = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // Register indexes on the configuration port (byte address bit 2)
    localparam logic REG_SYNC_FIRST  = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    // Register reset values
    localparam logic [7:0] SYNC_FIRST_RST  = 8'd181;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd98;

    // Sync byte settings handed to the parser
    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
    } t_cfg;

    // One result beat
    typedef struct packed {
        t_status     frame_status;
        logic [7:0]  msg_group;
        logic [7:0]  msg_ident;
        logic [15:0] payload_length;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
    } t_result;

endpackage

@@ rtl/core/spf_regs.sv @@
module spf_regs import spf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write the addressed sync register in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_SYNC_FIRST:  r_sync_first  <= pwdata[7:0];
                REG_SYNC_SECOND: r_sync_second <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (paddr[2])
            REG_SYNC_FIRST:  prdata = {24'd0, r_sync_first};
            REG_SYNC_SECOND: prdata = {24'd0, r_sync_second};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg.sync_first  = r_sync_first;
    assign o_cfg.sync_second = r_sync_second;

endmodule

@@ rtl/core/spf_parse.sv @@
module spf_parse import spf_pkg::*; #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [CNT_W-1:0] BUF_LIM = CNT_W'(BUFFER_BYTES);

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC1 = 3'd1,
        PH_SYNC2 = 3'd2,
        PH_CLASS = 3'd3,
        PH_LEN1  = 3'd4,
        PH_BODY  = 3'd5,
        PH_LEN2  = 3'd6
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_sum_a, n_sum_a;
    logic [7:0]       r_sum_b, n_sum_b;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_len, n_len;
    logic [7:0]       r_class, n_class;
    logic [7:0]       r_ident, n_ident;
    logic [7:0]       r_prev, n_prev;

    logic [7:0]       fold_a, fold_b;
    logic [16:0]      count_x, len_x, len_p1;
    t_status          status;
    logic             dvalid;
    logic [7:0]       dbyte, dindex;

    // Fletcher step on the incoming byte
    assign fold_a  = r_sum_a + i_rx_byte;
    assign fold_b  = r_sum_b + fold_a;
    assign count_x = 17'(r_count);
    assign len_x   = {1'b0, r_len};
    assign len_p1  = len_x + 17'd1;

    // Next state and result for one byte
    always_comb begin
        n_phase = r_phase;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_count = r_count;
        n_len   = r_len;
        n_class = r_class;
        n_ident = r_ident;
        n_prev  = r_prev;
        status  = ST_BUSY;
        dvalid  = 1'b0;
        dbyte   = 8'd0;
        dindex  = 8'd0;

        unique case (r_phase)
            PH_SYNC1: begin
                if (i_rx_byte == i_cfg.sync_second) begin
                    n_phase = PH_SYNC2;
                end else begin
                    n_phase = PH_HUNT;
                    n_sum_a = 8'd0;
                    n_sum_b = 8'd0;
                    n_count = '0;
                    n_len   = 16'd0;
                end
            end
            PH_SYNC2: begin
                n_sum_a = fold_a;
                n_sum_b = fold_b;
                n_class = i_rx_byte;
                n_phase = PH_CLASS;
            end
            PH_CLASS: begin
                n_sum_a = fold_a;
                n_sum_b = fold_b;
                n_ident = i_rx_byte;
                n_phase = PH_LEN1;
            end
            PH_LEN1: begin
                n_sum_a = fold_a;
                n_sum_b = fold_b;
                n_len   = {8'd0, i_rx_byte};
                n_phase = PH_LEN2;
            end
            PH_LEN2: begin
                n_sum_a = fold_a;
                n_sum_b = fold_b;
                n_len   = {i_rx_byte, r_len[7:0]};
                n_phase = PH_BODY;
            end
            PH_BODY: begin
                // second check byte, payload or first check byte, overflow
                priority if (count_x >= len_p1) begin
                    status = ((r_sum_a == r_prev) && (r_sum_b == i_rx_byte))
                             ? ST_GOOD : ST_CHK_ERR;
                end else if (r_count < BUF_LIM) begin
                    if (count_x < len_x) begin
                        n_sum_a = fold_a;
                        n_sum_b = fold_b;
                        dvalid  = 1'b1;
                        dbyte   = i_rx_byte;
                        dindex  = 8'(r_count);
                    end
                    n_count = r_count + CNT_W'(1);
                end else begin
                    status = ST_OVERFLOW;
                end
                n_prev = i_rx_byte;
            end
            default: begin
                n_phase = (i_rx_byte == i_cfg.sync_first) ? PH_SYNC1 : PH_HUNT;
            end
        endcase

        // Result shows the length before any frame-end clear
        o_result.frame_status   = status;
        o_result.msg_group      = n_class;
        o_result.msg_ident      = n_ident;
        o_result.payload_length = n_len;
        o_result.data_valid     = dvalid;
        o_result.data_byte      = dbyte;
        o_result.data_index     = dindex;

        // Drop back to hunting at frame end
        if (status != ST_BUSY) begin
            n_phase = PH_HUNT;
            n_sum_a = 8'd0;
            n_sum_b = 8'd0;
            n_count = '0;
            n_len   = 16'd0;
        end
    end

    // Hold parser state, advance on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_sum_a <= 8'd0;
            r_sum_b <= 8'd0;
            r_count <= '0;
            r_len   <= 16'd0;
            r_class <= 8'd0;
            r_ident <= 8'd0;
            r_prev  <= 8'd0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_count <= n_count;
            r_len   <= n_len;
            r_class <= n_class;
            r_ident <= n_ident;
            r_prev  <= n_prev;
        end
    end

endmodule

@@ rtl/core/spf_obuf.sv @@
module spf_obuf import spf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_take,
    input  t_result i_result,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_fire;

    assign out_fire = r_out_valid && !i_stall;

    // Output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_take) begin
            if (r_out_valid && i_stall) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload moves without reset
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (i_take) begin
            if (r_out_valid && i_stall) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

@@ rtl/core/sync_frame_parser_fletcher8.sv @@
// Channel   Direction  Handshake            Beat contents
// input     in         i_valid / o_stall    i_rx_byte
// result    out        o_valid / i_stall    status, header, payload byte and index
// config    in         APB psel / penable   sync_first (0x0), sync_second (0x4)
//
// One received byte is accepted per cycle while the skid entry is free; its result
// beat goes to the single output register, or to the skid entry behind a stalled output.
// The rate is set by the combinational Fletcher and length compare path.
// Synchronous active-low reset returns the parser to sync hunting and the
// sync registers to 0xB5 and 0x62. o_stall rises only once the skid entry
// behind a stalled output holds a beat.
module sync_frame_parser_fletcher8 import spf_pkg::*; #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_msg_group,
    output logic [7:0]  o_msg_ident,
    output logic [15:0] o_payload_length,
    output logic        o_data_valid,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_data_index,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    cfg;
    t_result parse_res;
    t_result out_res;
    logic    full;
    logic    take;

    // Accept a beat whenever the skid entry is free
    assign take    = i_valid && !full;
    assign o_stall = full;

    spf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    spf_parse #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (cfg),
        .o_result  (parse_res)
    );

    spf_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_result (parse_res),
        .o_full   (full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_res)
    );

    assign o_frame_status   = out_res.frame_status;
    assign o_msg_group      = out_res.msg_group;
    assign o_msg_ident      = out_res.msg_ident;
    assign o_payload_length = out_res.payload_length;
    assign o_data_valid     = out_res.data_valid;
    assign o_data_byte      = out_res.data_byte;
    assign o_data_index     = out_res.data_index;

endmodule

@@ rtl/core/spf_checker.sv @@
module spf_checker import spf_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_frame_status,
    input logic        o_data_valid,
    input logic [7:0]  o_data_byte,
    input logic [7:0]  o_data_index,
    input logic        pready
);

    // A payload beat never closes a frame
    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data_valid |-> o_frame_status == ST_BUSY)
        else $error("payload beat carries a frame-end status");

    // Non-payload beats carry zeroed data fields
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data_valid |-> o_data_byte == 8'd0 && o_data_index == 8'd0)
        else $error("data fields set on a non-payload beat");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_status)
            && $stable(o_data_valid) && $stable(o_data_byte))
        else $error("stalled result beat changed");

    // Reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    // Configuration port never waits
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind sync_frame_parser_fletcher8 spf_checker u_spf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_frame_status (o_frame_status),
    .o_data_valid   (o_data_valid),
    .o_data_byte    (o_data_byte),
    .o_data_index   (o_data_index),
    .pready         (pready)
);
